[src/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle, disabled in reset
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked in the next cycle, disabled in reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/spi_bm_pkg.sv]
// ----------------------------------------------------------------------------
// spi_bm_pkg
// Types, codes and helpers shared by the SPI burst master files.
// ----------------------------------------------------------------------------
package spi_bm_pkg;

  // sequencer phases, one-hot
  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_WAKE = 6'b000010,
    PH_LOW  = 6'b000100,
    PH_HIGH = 6'b001000,
    PH_GAP  = 6'b010000,
    PH_POLL = 6'b100000
  } phase_t;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_TICKS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL_GAP   = 2'd3;

  // register reset values
  localparam logic [15:0] WAKE_TICKS_RST     = 16'd3;
  localparam logic [7:0]  HALF_BIT_TICKS_RST = 8'd1;
  localparam logic [7:0]  ACK_POLL_LIMIT_RST = 8'd50;
  localparam logic [15:0] ACK_POLL_GAP_RST   = 16'd3;

  // ack status codes
  localparam logic [1:0] ACK_NONE    = 2'd0;
  localparam logic [1:0] ACK_SEEN    = 2'd1;
  localparam logic [1:0] ACK_TIMEOUT = 2'd2;

  // last bit index of a byte
  localparam logic [2:0] LAST_BIT = 3'd7;

  // stream widths and result bit positions in out_tdata
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_SCK_BIT    = 0;
  localparam int OUT_MOSI_BIT   = 1;
  localparam int OUT_CS_N_BIT   = 2;
  localparam int OUT_WAKE_N_BIT = 3;
  localparam int OUT_READY_BIT  = 4;
  localparam int OUT_RX_LSB     = 5;
  localparam int OUT_RXV_BIT    = 13;
  localparam int OUT_STAT_LSB   = 14;

  typedef struct packed {
    logic [15:0] wake_ticks;
    logic [7:0]  half_bit_ticks;
    logic [7:0]  ack_poll_limit;
    logic [15:0] ack_poll_gap;
  } cfg_t;

  typedef struct packed {
    logic       op;
    logic [7:0] tx_byte;
    logic       last_byte;
    logic       with_ack;
    logic       miso;
    logic       ack_level;
  } item_t;

  typedef struct packed {
    logic       sck;
    logic       mosi;
    logic       cs_n;
    logic       wake_n;
    logic       byte_ready;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       burst_done;
    logic [1:0] ack_status;
  } result_t;

  // a zero timing setting acts as one
  function automatic logic [15:0] at_least_one16(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic [7:0] at_least_one8(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage

[src/spi_bm_cfg.sv]
// ----------------------------------------------------------------------------
// spi_bm_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module spi_bm_cfg
  import spi_bm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  // register writes by index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wake_ticks     <= WAKE_TICKS_RST;
      cfg_r.half_bit_ticks <= HALF_BIT_TICKS_RST;
      cfg_r.ack_poll_limit <= ACK_POLL_LIMIT_RST;
      cfg_r.ack_poll_gap   <= ACK_POLL_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_WAKE_TICKS:     cfg_r.wake_ticks     <= cfg_wdata;
        CFG_HALF_BIT_TICKS: cfg_r.half_bit_ticks <= cfg_wdata[7:0];
        CFG_ACK_POLL_LIMIT: cfg_r.ack_poll_limit <= cfg_wdata[7:0];
        CFG_ACK_POLL_GAP:   cfg_r.ack_poll_gap   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[src/spi_bm_core.sv]
// ----------------------------------------------------------------------------
// spi_bm_core
// Burst sequencer: state registers and the per-tick next-state logic.
// ----------------------------------------------------------------------------
module spi_bm_core
  import spi_bm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic [2:0]  bit_count_r, bit_count_nxt;
  logic [7:0]  tx_shift_r, tx_shift_nxt;
  logic [7:0]  rx_shift_r, rx_shift_nxt;
  logic        ack_start_r, ack_start_nxt;
  logic [7:0]  poll_count_r, poll_count_nxt;
  logic        last_pending_r, last_pending_nxt;
  logic        ack_mode_r, ack_mode_nxt;

  logic [15:0] tick_inc;
  logic [15:0] half_ticks;
  logic        rx_valid;
  logic [7:0]  rx_out;
  logic        done;
  logic [1:0]  status;
  logic        cs_low;

  assign tick_inc   = tick_count_r + 16'd1;
  assign half_ticks = {8'd0, at_least_one8(cfg.half_bit_ticks)};

  // next state for one tick
  always_comb begin
    phase_nxt        = phase_r;
    tick_count_nxt   = tick_count_r;
    bit_count_nxt    = bit_count_r;
    tx_shift_nxt     = tx_shift_r;
    rx_shift_nxt     = rx_shift_r;
    ack_start_nxt    = ack_start_r;
    poll_count_nxt   = poll_count_r;
    last_pending_nxt = last_pending_r;
    ack_mode_nxt     = ack_mode_r;
    rx_valid         = 1'b0;
    rx_out           = 8'd0;
    done             = 1'b0;
    status           = ACK_NONE;
    unique case (phase_r)
      PH_WAKE: begin
        tick_count_nxt = tick_inc;
        if (tick_inc >= at_least_one16(cfg.wake_ticks)) begin
          bit_count_nxt  = 3'd0;
          phase_nxt      = PH_LOW;
          tick_count_nxt = 16'd0;
        end
      end
      PH_LOW: begin
        tick_count_nxt = tick_inc;
        // sample miso at the end of the low phase
        if (tick_inc >= half_ticks) begin
          rx_shift_nxt   = {rx_shift_r[6:0], item.miso};
          phase_nxt      = PH_HIGH;
          tick_count_nxt = 16'd0;
        end
      end
      PH_HIGH: begin
        tick_count_nxt = tick_inc;
        if (tick_inc >= half_ticks) begin
          tick_count_nxt = 16'd0;
          if (bit_count_r == LAST_BIT) begin
            // byte complete
            bit_count_nxt = 3'd0;
            rx_valid      = 1'b1;
            rx_out        = rx_shift_r;
            if (last_pending_r) begin
              if (ack_mode_r) begin
                phase_nxt      = PH_POLL;
                poll_count_nxt = 8'd0;
              end else begin
                phase_nxt = PH_IDLE;
                done      = 1'b1;
                status    = ACK_NONE;
              end
            end else begin
              phase_nxt = PH_GAP;
            end
          end else begin
            bit_count_nxt = bit_count_r + 3'd1;
            tx_shift_nxt  = {tx_shift_r[6:0], 1'b0};
            phase_nxt     = PH_LOW;
          end
        end
      end
      PH_GAP: begin
        if (item.op) begin
          tx_shift_nxt     = item.tx_byte;
          last_pending_nxt = item.last_byte;
          bit_count_nxt    = 3'd0;
          phase_nxt        = PH_LOW;
          tick_count_nxt   = 16'd0;
        end
      end
      PH_POLL: begin
        // wait out the gap, then check the ack line
        if (tick_count_r != 16'd0) begin
          tick_count_nxt = tick_count_r - 16'd1;
        end else if (poll_count_r >= cfg.ack_poll_limit) begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
          status    = ACK_TIMEOUT;
        end else if (item.ack_level != ack_start_r) begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
          status    = ACK_SEEN;
        end else begin
          poll_count_nxt = poll_count_r + 8'd1;
          tick_count_nxt = at_least_one16(cfg.ack_poll_gap) - 16'd1;
        end
      end
      default: begin
        // idle: a byte offer starts the wake phase
        if (item.op) begin
          ack_start_nxt    = item.ack_level;
          ack_mode_nxt     = item.with_ack;
          tx_shift_nxt     = item.tx_byte;
          last_pending_nxt = item.last_byte;
          tick_count_nxt   = 16'd0;
          phase_nxt        = PH_WAKE;
        end
      end
    endcase
  end

  // pin levels after the tick
  assign cs_low = (phase_nxt == PH_LOW) || (phase_nxt == PH_HIGH) || (phase_nxt == PH_GAP);

  always_comb begin
    res.sck        = (phase_nxt != PH_LOW);
    res.cs_n       = !cs_low;
    res.wake_n     = !(cs_low || (phase_nxt == PH_WAKE));
    res.mosi       = cs_low ? tx_shift_nxt[7] : 1'b1;
    res.byte_ready = (phase_nxt == PH_IDLE) || (phase_nxt == PH_GAP);
    res.rx_byte    = rx_out;
    res.rx_valid   = rx_valid;
    res.burst_done = done;
    res.ack_status = status;
  end

  // state registers, advance once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      tick_count_r   <= 16'd0;
      bit_count_r    <= 3'd0;
      tx_shift_r     <= 8'd0;
      rx_shift_r     <= 8'd0;
      ack_start_r    <= 1'b0;
      poll_count_r   <= 8'd0;
      last_pending_r <= 1'b0;
      ack_mode_r     <= 1'b0;
    end else if (step_en) begin
      phase_r        <= phase_nxt;
      tick_count_r   <= tick_count_nxt;
      bit_count_r    <= bit_count_nxt;
      tx_shift_r     <= tx_shift_nxt;
      rx_shift_r     <= rx_shift_nxt;
      ack_start_r    <= ack_start_nxt;
      poll_count_r   <= poll_count_nxt;
      last_pending_r <= last_pending_nxt;
      ack_mode_r     <= ack_mode_nxt;
    end
  end

endmodule

[src/spi_burst_master_with_ack_poll.sv]
// ----------------------------------------------------------------------------
// spi_burst_master_with_ack_poll
// Tick-driven SPI mode 3 burst master with wake line and ACK line polling.
// ----------------------------------------------------------------------------
//   channel  | dir | tdata / tuser / tlast
//   in_      | in  | tick item: byte, miso, ack level; op and mode in tuser
//   out_     | out | pin levels, ready, received byte, status; tlast = done
//   cfg_     | in  | register index and write data, no read-back
//
// One item per clock cycle while out_ does not stall: an input register, the
// sequencer next-state logic and a result register; each item passes from the input register to the result register.
// Reset puts the sequencer in idle and loads the register defaults.
// A stall on out_ holds the result and the input register, so in_tready
// drops only while both stages are full.
// ----------------------------------------------------------------------------
module spi_burst_master_with_ack_poll
  import spi_bm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input: tdata = tx_byte[7:0], miso[8], ack_level[9], zero[15:10]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // input: tuser = op[0], with_ack[1]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   in_tlast,
  // result: tdata = sck[0], mosi[1], cs_n[2], wake_n[3], byte_ready[4],
  //         rx_byte[12:5], rx_valid[13], ack_status[15:14]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t    cfg;
  item_t   in_item_r, in_item_nxt;
  logic    in_valid_r, in_valid_nxt;
  logic    out_valid_r, out_valid_nxt;
  result_t res;
  result_t out_res_r;
  logic    advance;
  logic    in_take;

  spi_bm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  spi_bm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_item_r),
    .cfg     (cfg),
    .res     (res)
  );

  // handshake
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  // unpack the input item
  always_comb begin
    in_item_nxt.op        = in_tuser[0];
    in_item_nxt.with_ack  = in_tuser[1];
    in_item_nxt.tx_byte   = in_tdata[7:0];
    in_item_nxt.miso      = in_tdata[8];
    in_item_nxt.ack_level = in_tdata[9];
    in_item_nxt.last_byte = in_tlast;
  end

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item_nxt;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  // pack the result item
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.burst_done;
  always_comb begin
    out_tdata                 = '0;
    out_tdata[OUT_SCK_BIT]    = out_res_r.sck;
    out_tdata[OUT_MOSI_BIT]   = out_res_r.mosi;
    out_tdata[OUT_CS_N_BIT]   = out_res_r.cs_n;
    out_tdata[OUT_WAKE_N_BIT] = out_res_r.wake_n;
    out_tdata[OUT_READY_BIT]  = out_res_r.byte_ready;
    out_tdata[OUT_RX_LSB +: 8] = out_res_r.rx_byte;
    out_tdata[OUT_RXV_BIT]    = out_res_r.rx_valid;
    out_tdata[OUT_STAT_LSB +: 2] = out_res_r.ack_status;
  end

endmodule

[src/spi_bm_checker.sv]
// ----------------------------------------------------------------------------
// spi_bm_checker
// Port-level checks on the SPI burst master, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spi_bm_checker
  import spi_bm_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  logic [OUT_TDATA_W:0] out_word;
  logic                 sck;
  logic                 mosi;
  logic                 cs_n;
  logic                 wake_n;
  logic                 byte_rdy;
  logic [1:0]           stat;
  logic                 stat_ok;

  // result fields as seen on the port
  assign out_word = {out_tlast, out_tdata};
  assign sck      = out_tdata[OUT_SCK_BIT];
  assign mosi     = out_tdata[OUT_MOSI_BIT];
  assign cs_n     = out_tdata[OUT_CS_N_BIT];
  assign wake_n   = out_tdata[OUT_WAKE_N_BIT];
  assign byte_rdy = out_tdata[OUT_READY_BIT];
  assign stat     = out_tdata[OUT_STAT_LSB +: 2];
  assign stat_ok  = (stat == ACK_NONE) || (stat == ACK_SEEN) || (stat == ACK_TIMEOUT);

  // stalled result holds
  `ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_word))

  // clock only runs low while chip select is active
  `ASSERT_SAME(a_sck_needs_cs, out_tvalid && !sck, !cs_n)

  // chip select active implies the wake line is held low
  `ASSERT_SAME(a_cs_wake, out_tvalid && !cs_n, !wake_n)

  // released mosi idles high
  `ASSERT_SAME(a_mosi_idle, out_tvalid && cs_n, mosi)

  // end of burst leaves chip select and wake released, ready, and a valid status code
  `ASSERT_SAME(a_done_release, out_tvalid && out_tlast, cs_n && wake_n && byte_rdy && stat_ok)

endmodule

bind spi_burst_master_with_ack_poll spi_bm_checker u_spi_bm_checker (.*);
